// ===== hw/rtl/adtshi_pkg.sv =====
package adtshi_pkg;

  // Largest output frame, header included, that the block will build.
  localparam int unsigned MAX_FRAME_BYTES = 8191;

  localparam int unsigned HDR_LEN     = 7;
  localparam int unsigned HELD_DEPTH  = 4;
  localparam int unsigned BURST_MAX   = HDR_LEN + HELD_DEPTH;
  // One waiting result plus the longest burst that one request can cause.
  localparam int unsigned QUEUE_DEPTH = BURST_MAX + 1;

  localparam int unsigned RATE_W    = 17;
  localparam int unsigned RATE_NUM  = 13;
  localparam logic [3:0]  RATE_IDX_DEFAULT = 4'd3;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_PROFILE     = 2'd1;
  localparam logic [1:0] CFG_CHANNELS    = 2'd2;

  localparam logic [1:0] PROFILE_LC = 2'd1;

  typedef enum logic [1:0] {
    MODE_DECIDE = 2'd0,
    MODE_PASS   = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_DROP   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       hdr;
    logic       err;
  } entry_t;

  localparam logic [RATE_W-1:0] RATE_TABLE [RATE_NUM] = '{
    17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
    17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
    17'd7350
  };

  // Maps a sample rate in Hz to its ADTS index; unknown rates give the 48 kHz index.
  function automatic logic [3:0] rate_index(input logic [RATE_W-1:0] rate_hz);
    logic [3:0] idx;
    idx = RATE_IDX_DEFAULT;
    for (int i = RATE_NUM - 1; i >= 0; i--) begin
      if (RATE_TABLE[i] == rate_hz) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/adts_header_inserter_core.sv =====
// ADTS header inserter. Raw AAC frame bytes come in one per request together with the
// frame's payload length and a last-byte mark; the first four bytes are held and compared
// with the ADTS header built from the configuration, so frames that already carry a
// matching header pass unchanged and all others get a 7-byte header in front. A frame
// without a matching header whose length with header exceeds the size limit is
// dropped and reported by a single result with frame_error set. Payload bytes go
// through the output queue at one per cycle while the output keeps taking them. The
// fourth byte of a frame (or an earlier last byte) releases a burst of up to 11 results
// into a 12-entry output queue, and the input stalls until it has drained to one entry.
// Configuration writes are always accepted and must only be made while the block is idle.
module adts_header_inserter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [12:0] frame_bytes,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        header_added,
  output logic        frame_error
);

  localparam int unsigned QD = adtshi_pkg::QUEUE_DEPTH;
  localparam int unsigned BM = adtshi_pkg::BURST_MAX;
  localparam int unsigned HL = adtshi_pkg::HDR_LEN;
  localparam int unsigned HD = adtshi_pkg::HELD_DEPTH;

  logic [3:0] rate_idx;
  logic [1:0] profile;
  logic [2:0] chan;

  adtshi_pkg::mode_t mode, mode_next;
  logic [1:0] byte_position;
  logic [7:0] held [HD];

  adtshi_pkg::entry_t slot [QD];
  adtshi_pkg::entry_t slot_next [QD];
  adtshi_pkg::entry_t shifted [QD];
  logic [3:0] q_cnt, q_cnt_next, base;

  adtshi_pkg::entry_t res [BM];
  logic [3:0] res_n;

  logic        push, pop, decide_now, match, oversize;
  logic [12:0] len;
  logic [13:0] total;
  logic [2:0]  held_n;
  logic [7:0]  hb  [HD];
  logic [7:0]  hdr [HL];

  assign cfg_ready = 1'b1;
  assign in_ready  = (q_cnt <= 4'd1);
  assign out_valid = (q_cnt != 4'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  assign out_byte     = slot[0].value;
  assign out_last     = slot[0].last;
  assign header_added = slot[0].hdr;
  assign frame_error  = slot[0].err;

  assign total    = {1'b0, frame_bytes} + 14'(HL);
  assign len      = total[12:0];
  assign oversize = (total > 14'(adtshi_pkg::MAX_FRAME_BYTES));
  assign held_n   = {1'b0, byte_position} + 3'd1;

  always_comb begin
    hdr[0] = 8'hFF;
    hdr[1] = 8'hF1;
    hdr[2] = {profile, rate_idx, 1'b0, chan[2]};
    hdr[3] = {chan[1:0], 4'b0000, len[12:11]};
    hdr[4] = len[10:3];
    hdr[5] = {len[2:0], 5'h1F};
    hdr[6] = 8'hFC;
    for (int i = 0; i < HD; i++) begin
      hb[i] = (byte_position == 2'(i)) ? data_byte : held[i];
    end
  end

  assign decide_now = (mode == adtshi_pkg::MODE_DECIDE) &&
                      ((byte_position == 2'(HD - 1)) || last_byte);
  // Byte 1 ignores the MPEG version bit and byte 3 the length bits, as in a real stream.
  assign match = (byte_position == 2'(HD - 1)) && (frame_bytes >= 13'(HL)) &&
                 (hb[0] == hdr[0]) &&
                 ((hb[1] & 8'hF7) == (hdr[1] & 8'hF7)) &&
                 (hb[2] == hdr[2]) &&
                 ((hb[3] & 8'hF0) == (hdr[3] & 8'hF0));

  always_comb begin
    for (int k = 0; k < BM; k++) begin
      res[k] = '0;
    end
    res_n     = 4'd0;
    mode_next = mode;
    case (mode)
      adtshi_pkg::MODE_DECIDE: begin
        if (decide_now) begin
          if (match) begin
            mode_next = adtshi_pkg::MODE_PASS;
            res_n     = {1'b0, held_n};
            for (int k = 0; k < HD; k++) begin
              res[k].value = hb[k];
              res[k].last  = last_byte && (held_n == 3'(k + 1));
            end
          end else if (oversize) begin
            mode_next  = adtshi_pkg::MODE_DROP;
            res_n      = 4'd1;
            res[0].err = 1'b1;
          end else begin
            mode_next = adtshi_pkg::MODE_INSERT;
            res_n     = 4'(HL) + {1'b0, held_n};
            for (int k = 0; k < HL; k++) begin
              res[k].value = hdr[k];
              res[k].hdr   = 1'b1;
            end
            for (int k = 0; k < HD; k++) begin
              res[HL + k].value = hb[k];
              res[HL + k].last  = last_byte && (held_n == 3'(k + 1));
              res[HL + k].hdr   = 1'b1;
            end
          end
        end
      end
      adtshi_pkg::MODE_PASS: begin
        res_n        = 4'd1;
        res[0].value = data_byte;
        res[0].last  = last_byte;
      end
      adtshi_pkg::MODE_INSERT: begin
        res_n        = 4'd1;
        res[0].value = data_byte;
        res[0].last  = last_byte;
        res[0].hdr   = 1'b1;
      end
      default: begin
        res_n = 4'd0;
      end
    endcase
    if (last_byte) begin
      mode_next = adtshi_pkg::MODE_DECIDE;
    end
  end

  // Output queue: shift out at the head, append a request's results behind what remains.
  always_comb begin
    base = q_cnt - {3'b000, pop};
    for (int j = 0; j < QD - 1; j++) begin
      shifted[j] = pop ? slot[j + 1] : slot[j];
    end
    shifted[QD - 1] = slot[QD - 1];
    for (int j = 0; j < QD; j++) begin
      slot_next[j] = shifted[j];
      for (int k = 0; k < BM; k++) begin
        if (push && (4'(k) < res_n) && (base + 4'(k) == 4'(j))) begin
          slot_next[j] = res[k];
        end
      end
    end
    q_cnt_next = base + (push ? res_n : 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_idx      <= adtshi_pkg::RATE_IDX_DEFAULT;
      profile       <= adtshi_pkg::PROFILE_LC;
      chan          <= 3'd2;
      mode          <= adtshi_pkg::MODE_DECIDE;
      byte_position <= 2'd0;
      q_cnt         <= 4'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          adtshi_pkg::CFG_SAMPLE_RATE: rate_idx <= adtshi_pkg::rate_index(cfg_data);
          adtshi_pkg::CFG_PROFILE: begin
            profile <= (cfg_data[3:0] >= 4'd3) ? adtshi_pkg::PROFILE_LC : cfg_data[1:0];
          end
          adtshi_pkg::CFG_CHANNELS: chan <= cfg_data[2:0];
          default: begin
          end
        endcase
      end
      q_cnt <= q_cnt_next;
      if (push) begin
        mode <= mode_next;
        if (decide_now || last_byte) begin
          byte_position <= 2'd0;
        end else if (mode == adtshi_pkg::MODE_DECIDE) begin
          byte_position <= byte_position + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QD; j++) begin
      slot[j] <= slot_next[j];
    end
    if (push && (mode == adtshi_pkg::MODE_DECIDE)) begin
      held[byte_position] <= data_byte;
    end
  end

endmodule

// ===== verif/adts_header_inserter_core_checker.sv =====
// Header builder shared by the stimulus side (to make frames that already carry a
// matching header) and by the checker (to predict what the block emits).
package adts_frame_tb_pkg;

  import adtshi_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam int unsigned RATE_HZ [13] = '{
    96000, 88200, 64000, 48000, 44100, 32000, 24000, 22050, 16000, 12000, 11025,
    8000, 7350
  };

  function automatic logic [6:0][7:0] adts_header(input logic [16:0] rate_hz,
                                                  input logic [3:0]  profile,
                                                  input logic [2:0]  chans,
                                                  input logic [12:0] payload);
    logic [6:0][7:0] h;
    logic [3:0]      idx;
    logic [1:0]      prof;
    logic [12:0]     len;
    bit              found;
    idx = 4'd3;
    found = 1'b0;
    for (int i = 0; i < 13; i++) begin
      if (!found && RATE_HZ[i] == rate_hz) begin
        idx = 4'(i);
        found = 1'b1;
      end
    end
    prof = (profile >= 4'd3) ? PROFILE_LC : profile[1:0];
    // The length field holds only 13 bits and wraps for oversized payloads.
    len = payload + 13'd7;
    h[0] = 8'hFF;
    h[1] = 8'hF1;
    h[2] = {prof, idx, 1'b0, chans[2]};
    h[3] = {chans[1:0], 4'b0000, len[12:11]};
    h[4] = len[10:3];
    h[5] = {len[2:0], 5'h1F};
    h[6] = 8'hFC;
    return h;
  endfunction

endpackage

module adts_header_inserter_core_checker
  import adtshi_pkg::*;
  import adts_frame_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [12:0] frame_bytes,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  input  logic        header_added,
  input  logic        frame_error,
  output int          mismatches,
  output int          outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [16:0] rate_hz;
  logic [3:0]  profile;
  logic [2:0]  chans;
  logic [12:0] seen_count;
  logic [7:0]  lead_bytes [4];
  mode_t       mode;
  entry_t      expected_stream [$];

  task automatic queue_byte(input logic [7:0] value, input logic last, input logic hdr,
                            input logic err);
    entry_t e;
    e.value = value;
    e.last = last;
    e.hdr = hdr;
    e.err = err;
    expected_stream.push_back(e);
  endtask

  task automatic predict_frame_byte(input logic [7:0] b, input logic [12:0] fb,
                                    input logic last);
    logic [6:0][7:0] hdr;
    bit              match;
    int              nheld;
    if (mode == MODE_DECIDE) begin
      if (seen_count < 13'd4) lead_bytes[seen_count[1:0]] = b;
      if (seen_count != 13'h1FFF) seen_count++;
      // The decision waits for the fourth byte unless the frame ends first.
      if (seen_count >= 13'd4 || last) begin
        hdr = adts_header(rate_hz, profile, chans, fb);
        match = seen_count >= 13'd4 && fb >= 13'(HDR_LEN) &&
                lead_bytes[0] == hdr[0] &&
                (lead_bytes[1] & 8'hF7) == (hdr[1] & 8'hF7) &&
                lead_bytes[2] == hdr[2] &&
                (lead_bytes[3] & 8'hF0) == (hdr[3] & 8'hF0);
        nheld = (seen_count < 13'd4) ? int'(seen_count) : 4;
        if (match) begin
          mode = MODE_PASS;
          for (int i = 0; i < nheld; i++)
            queue_byte(lead_bytes[i], (i + 1 == nheld) ? last : 1'b0, 1'b0, 1'b0);
        end else if (int'(fb) + HDR_LEN > MAX_FRAME_BYTES) begin
          mode = MODE_DROP;
          queue_byte(8'h00, 1'b0, 1'b0, 1'b1);
        end else begin
          mode = MODE_INSERT;
          for (int i = 0; i < HDR_LEN; i++) queue_byte(hdr[i], 1'b0, 1'b1, 1'b0);
          for (int i = 0; i < nheld; i++)
            queue_byte(lead_bytes[i], (i + 1 == nheld) ? last : 1'b0, 1'b1, 1'b0);
        end
      end
    end else begin
      if (seen_count != 13'h1FFF) seen_count++;
      if (mode == MODE_PASS) queue_byte(b, last, 1'b0, 1'b0);
      else if (mode == MODE_INSERT) queue_byte(b, last, 1'b1, 1'b0);
    end
    if (last) begin
      mode = MODE_DECIDE;
      seen_count = '0;
    end
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    entry_t e;
    if (rst) begin
      rate_hz = 17'd48000;
      profile = 4'd1;
      chans = 3'd2;
      seen_count = '0;
      mode = MODE_DECIDE;
      expected_stream.delete();
    end else begin
      // Results are compared before this edge's request is predicted, since a
      // request never shows up at the output in the cycle it is accepted.
      if (out_valid && out_ready) begin
        if (expected_stream.size() == 0) begin
          $error("unexpected result: out_byte %02h out_last %0b header_added %0b frame_error %0b",
                 out_byte, out_last, header_added, frame_error);
          mismatches++;
        end else begin
          e = expected_stream.pop_front();
          if (out_byte !== e.value) begin
            $error("out_byte: expected %02h, got %02h", e.value, out_byte);
            mismatches++;
          end
          if (out_last !== e.last) begin
            $error("out_last: expected %0b, got %0b", e.last, out_last);
            mismatches++;
          end
          if (header_added !== e.hdr) begin
            $error("header_added: expected %0b, got %0b", e.hdr, header_added);
            mismatches++;
          end
          if (frame_error !== e.err) begin
            $error("frame_error: expected %0b, got %0b", e.err, frame_error);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) predict_frame_byte(data_byte, frame_bytes, last_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLE_RATE: rate_hz = cfg_data;
          CFG_PROFILE:     profile = cfg_data[3:0];
          CFG_CHANNELS:    chans = cfg_data[2:0];
          default: ;
        endcase
      end
    end
    outstanding = expected_stream.size();
  end

endmodule

// ===== verif/adts_header_inserter_core_tb.sv =====
module adts_header_inserter_core_tb;

  import adtshi_pkg::*;
  import adts_frame_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {LEAD_RANDOM, LEAD_HEADER, LEAD_BROKEN} lead_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;
  logic        in_valid, in_ready;
  logic [7:0]  data_byte;
  logic [12:0] frame_bytes;
  logic        last_byte;
  logic        out_valid, out_ready;
  logic [7:0]  out_byte;
  logic        out_last, header_added, frame_error;
  int          mismatches, outstanding;

  // Mirror of the configuration, used to build frames that already carry a header.
  logic [16:0] cur_rate = 17'd48000;
  logic [3:0]  cur_prof = 4'd1;
  logic [2:0]  cur_chans = 3'd2;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  bit          held_off = 1'b0;
  int          results_taken = 0;

  always #4 clk = ~clk;

  adts_header_inserter_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .frame_bytes  (frame_bytes),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .header_added (header_added),
    .frame_error  (frame_error)
  );

  adts_header_inserter_core_checker stream_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .frame_bytes  (frame_bytes),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .header_added (header_added),
    .frame_error  (frame_error),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  task automatic send_byte(input logic [7:0] b, input logic [12:0] fb, input logic last);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    frame_bytes <= fb;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input logic [12:0] fb, input lead_t lead);
    logic [6:0][7:0] hdr;
    logic [7:0]      b;
    int              bad;
    hdr = adts_header(cur_rate, cur_prof, cur_chans, fb);
    bad = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (lead != LEAD_RANDOM && i < 4) begin
        b = hdr[i];
        // Bits outside the compared masks are free.
        if (i == 1) b[3] = 1'($urandom);
        if (i == 3) b[3:0] = 4'($urandom);
        if (lead == LEAD_BROKEN && i == bad) b = b ^ (8'h10 << $urandom_range(0, 3));
      end else if (i == 0 && $urandom_range(0, 2) == 0) begin
        b = 8'hFF;
      end
      send_byte(b, fb, i == len - 1);
    end
  endtask

  task automatic random_frames(input int budget);
    int          sent;
    int          len;
    int          kind;
    logic [12:0] fb;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(4, 16);
        fb = ($urandom_range(0, 3) != 0) ? 13'(len) : 13'($urandom_range(7, 8184));
        send_frame(len, fb, LEAD_HEADER);
      end else if (kind < 68) begin
        len = $urandom_range(1, 12);
        fb = ($urandom_range(0, 1) != 0) ? 13'(len) : 13'($urandom_range(0, 8184));
        send_frame(len, fb, LEAD_RANDOM);
      end else if (kind < 78) begin
        len = $urandom_range(4, 10);
        send_frame(len, 13'($urandom_range(7, 8184)), LEAD_BROKEN);
      end else if (kind < 88) begin
        // Oversized lengths; a header built for them has a wrapped length field.
        len = $urandom_range(1, 8);
        send_frame(len, 13'($urandom_range(8185, 8191)),
                   ($urandom_range(0, 1) != 0) ? LEAD_HEADER : LEAD_RANDOM);
      end else begin
        len = $urandom_range(1, 3);
        send_frame(len, 13'($urandom_range(0, 8191)),
                   ($urandom_range(0, 1) != 0) ? LEAD_HEADER : LEAD_RANDOM);
      end
      sent += len;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [16:0] rate, input logic [3:0] prof,
                            input logic [2:0] chans);
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_PROFILE, 17'(prof));
    write_reg(CFG_CHANNELS, 17'(chans));
    cfg_valid <= 1'b0;
    cur_rate = rate;
    cur_prof = prof;
    cur_chans = chans;
  endtask

  // Wait until every predicted result has left, plus a margin for requests that
  // cause no result and may still be inside the block.
  task automatic drain;
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (16) @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      int stall;
      if (results_taken == 150 && !held_off) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      stall = rx_stalls_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      if (results_taken % 40 == 0) rx_stalls_on = ($urandom_range(0, 2) != 0);
      @(negedge clk);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("adts_header_inserter_core verification failed");
    $finish;
  end

  initial begin
    logic [16:0] rate;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    frame_bytes = '0;
    last_byte = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames under the reset configuration.
    send_frame(1, 13'd1, LEAD_RANDOM);
    send_frame(4, 13'd9, LEAD_HEADER);
    send_frame(4, 13'd4, LEAD_HEADER);
    send_frame(2, 13'd8191, LEAD_RANDOM);
    send_frame(5, 13'd8185, LEAD_RANDOM);
    send_frame(4, 13'd0, LEAD_RANDOM);
    send_frame(5, 13'd7, LEAD_BROKEN);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: set_config(17'd96000, 4'd0, 3'd0);
        1: set_config(17'd7350, 4'd15, 3'd7);
        2: begin
          write_reg(CFG_SPARE, 17'($urandom));
          set_config(17'h1FFFF, 4'd3, 3'd4);
        end
        3: set_config(17'd0, 4'd2, 3'd5);
        default: begin
          rate = ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                             : 17'(RATE_HZ[$urandom_range(0, 12)]);
          set_config(rate, 4'($urandom), 3'($urandom));
        end
      endcase
      tx_gaps_on = (ph % 3 != 1);
      random_frames(48);
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("adts_header_inserter_core verification clean");
    end else begin
      $display("adts_header_inserter_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/adtshi_pkg.sv
hw/rtl/adts_header_inserter_core.sv
verif/adts_header_inserter_core_checker.sv
verif/adts_header_inserter_core_tb.sv
